>>> design/kbsf_pkg.sv
// Package for the keyboard shift-flag tracker: beat types, state type and scan code constants.
package kbsf_pkg;

    // Set-1 scan codes with the break bit stripped
    localparam logic [6:0] SC_RSHIFT   = 7'h36;
    localparam logic [6:0] SC_LSHIFT   = 7'h2A;
    localparam logic [6:0] SC_CTRL     = 7'h1D;
    localparam logic [6:0] SC_SYSRQ    = 7'h37;
    localparam logic [6:0] SC_ALT      = 7'h38;
    localparam logic [6:0] SC_SCROLL   = 7'h46;
    localparam logic [6:0] SC_NUMPAUSE = 7'h45;
    localparam logic [6:0] SC_CAPS     = 7'h3A;
    localparam logic [6:0] SC_INSERT   = 7'h52;

    // Full raw bytes
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam int unsigned BREAK_BIT = 7;

    // Flag byte bit positions
    localparam int unsigned FB_RSHIFT = 0;
    localparam int unsigned FB_LSHIFT = 1;
    localparam int unsigned FB_CTRL   = 2;
    localparam int unsigned FB_ALT    = 3;
    localparam int unsigned FB_SCROLL = 4;
    localparam int unsigned FB_NUM    = 5;
    localparam int unsigned FB_CAPS   = 6;
    localparam int unsigned FB_INSERT = 7;

    localparam int unsigned PB_LCTRL  = 0;
    localparam int unsigned PB_LALT   = 1;
    localparam int unsigned PB_PAUSE  = 3;

    // Held-type bits (set on make, clear on break) versus toggle bits
    localparam logic [7:0] HELD_MASK   = 8'h0F;
    localparam logic [7:0] TOGGLE_MASK = 8'hF0;

    typedef struct packed {
        logic [7:0] scan_code;
        logic [7:0] ascii_code;
    } t_in_beat;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic [7:0] scan_out;
        logic       needs_translation;
        logic [7:0] shift_flags;
        logic [7:0] press_flags;
        logic       pause_event;
    } t_out_beat;

    typedef struct packed {
        logic       prefix_seen;
        logic [7:0] shift_byte;
        logic [7:0] press_byte;
    } t_kb_state;

endpackage

>>> design/kbsf_decode.sv
// Scan code decode and flag byte update for one beat.
module kbsf_decode (
    input  kbsf_pkg::t_in_beat  i_beat,
    input  kbsf_pkg::t_kb_state i_state,
    output kbsf_pkg::t_kb_state o_state,
    output kbsf_pkg::t_out_beat o_result
);

    logic [6:0] code;
    logic       brk;
    logic       ext;
    logic       is_mod;
    logic       is_pause;
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] shift_new;
    logic [7:0] press_new;
    logic       emits;

    assign code = i_beat.scan_code[6:0];
    assign brk  = i_beat.scan_code[kbsf_pkg::BREAK_BIT];
    assign ext  = i_state.prefix_seen || (i_beat.scan_code == kbsf_pkg::SC_PREFIX);

    always_comb begin
        m1       = '0;
        m2       = '0;
        is_mod   = 1'b0;
        is_pause = 1'b0;
        unique case (code)
            kbsf_pkg::SC_RSHIFT: begin
                m1[kbsf_pkg::FB_RSHIFT] = 1'b1;
                is_mod = 1'b1;
            end
            kbsf_pkg::SC_LSHIFT: begin
                m1[kbsf_pkg::FB_LSHIFT] = 1'b1;
                is_mod = 1'b1;
            end
            kbsf_pkg::SC_CTRL: begin
                m1[kbsf_pkg::FB_CTRL]  = 1'b1;
                m2[kbsf_pkg::PB_LCTRL] = !ext;
                is_mod = 1'b1;
            end
            kbsf_pkg::SC_SYSRQ: begin
                is_mod = 1'b1;
            end
            kbsf_pkg::SC_ALT: begin
                m1[kbsf_pkg::FB_ALT]  = 1'b1;
                m2[kbsf_pkg::PB_LALT] = !ext;
                is_mod = 1'b1;
            end
            kbsf_pkg::SC_SCROLL: begin
                m1[kbsf_pkg::FB_SCROLL] = 1'b1;
                m2[kbsf_pkg::FB_SCROLL] = !ext;
                is_mod = 1'b1;
            end
            kbsf_pkg::SC_NUMPAUSE: begin
                is_mod = 1'b1;
                m1[kbsf_pkg::FB_NUM] = ext;
                m2[kbsf_pkg::FB_NUM] = ext;
                is_pause = !ext && !brk;
            end
            kbsf_pkg::SC_CAPS: begin
                m1[kbsf_pkg::FB_CAPS] = 1'b1;
                m2[kbsf_pkg::FB_CAPS] = 1'b1;
                is_mod = 1'b1;
            end
            kbsf_pkg::SC_INSERT: begin
                m1[kbsf_pkg::FB_INSERT] = 1'b1;
                m2[kbsf_pkg::FB_INSERT] = 1'b1;
            end
            default: begin
                is_mod = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (!brk) begin
            press_new = i_state.press_byte | m2;
            shift_new = (i_state.shift_byte | (m1 & kbsf_pkg::HELD_MASK))
                        ^ (m1 & kbsf_pkg::TOGGLE_MASK);
        end else begin
            press_new = i_state.press_byte & ~m2;
            shift_new = i_state.shift_byte & ~(m1 & kbsf_pkg::HELD_MASK);
        end
    end

    assign emits = !brk && !(is_mod && (i_beat.ascii_code == 8'h00));

    always_comb begin
        o_result = '0;
        o_result.shift_flags = shift_new;
        o_result.press_flags = press_new;
        o_result.pause_event = is_pause;
        if (emits) begin
            o_result.scan_out = i_beat.scan_code;
            if (i_beat.ascii_code != 8'h00) begin
                o_result.char_valid = 1'b1;
                o_result.char_out   = shift_new[kbsf_pkg::FB_ALT] ? 8'h00 : i_beat.ascii_code;
            end else begin
                o_result.needs_translation = 1'b1;
            end
        end
    end

    assign o_state.prefix_seen = (i_beat.scan_code == kbsf_pkg::SC_PREFIX);
    assign o_state.shift_byte  = shift_new;
    assign o_state.press_byte  = press_new;

endmodule

>>> design/keyboard_shift_flag_tracker.sv
// Top level of the keyboard shift-flag tracker: input register, decode, result register.
//
//   channel  direction  handshake                payload
//   in       sink       i_in_valid / o_in_stall  i_in_beat  (scan_code, ascii_code)
//   out      source     o_out_valid / i_out_stall o_out_beat (flags, char, scan, events)
//
// One beat per cycle sustained while the output is not stalled. A beat waits
// in the input register, is decoded against the flag state and lands in the
// result register, which holds it until the output is not stalled.
// Flag state updates as a beat moves into the result register, so each beat
// sees the state left by the one before it.
// Synchronous active-low reset clears valids, the prefix flag and both flag bytes.
// A stall on the output holds the result register; the input register then
// holds too and o_in_stall rises only once it is occupied.
module keyboard_shift_flag_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  kbsf_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output kbsf_pkg::t_out_beat  o_out_beat
);

    // Input register
    logic                 r_in_valid;
    kbsf_pkg::t_in_beat   r_in_beat;

    // Result register
    logic                 r_out_valid;
    kbsf_pkg::t_out_beat  r_out_beat;

    // Keyboard state (prefix, flag bytes)
    kbsf_pkg::t_kb_state  r_state;
    kbsf_pkg::t_kb_state  n_state;
    kbsf_pkg::t_out_beat  n_result;

    logic out_free;   // result register can take a beat this cycle
    logic advance;    // input register moves into the result register
    logic in_take;    // input beat accepted

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    kbsf_decode u_decode (
        .i_beat   (r_in_beat),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= i_in_beat;
        end
        if (advance) begin
            r_out_beat <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

>>> design/kbsf_checker.sv
// Port-level assertions for the keyboard shift-flag tracker, bound to the top level.
module kbsf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input kbsf_pkg::t_in_beat  i_in_beat,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input kbsf_pkg::t_out_beat o_out_beat
);

    // A character and a translation request never share a beat
    a_char_xor_xlat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_beat.char_valid && o_out_beat.needs_translation))
        else $error("char_valid and needs_translation both set");

    // No character entry means a zero character
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.char_valid) |-> (o_out_beat.char_out == 8'h00))
        else $error("char_out nonzero without char_valid");

    // Pause press bit and the unused bit are never set
    a_press_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.press_flags[kbsf_pkg::PB_PAUSE:2] == 2'b00))
        else $error("pause or reserved press bit set");

    // A stalled result holds its beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled result beat changed");

    // A stalled input beat stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_beat)))
        else $error("stalled input beat changed");

endmodule

bind keyboard_shift_flag_tracker kbsf_checker u_kbsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

>>> verif/keyboard_shift_flag_tracker_tb.sv
// Testbench for the keyboard shift-flag tracker: random key traffic checked against a flag model.
module keyboard_shift_flag_tracker_tb;

    // Generous ceiling: about 1500 beats with random gaps and stalls, plus two
    // long receiver hold-offs, fit well under this.
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    // Key side (into the block) and flag side (out of the block)
    logic                 key_valid = 1'b0;
    logic                 key_stall;
    kbsf_pkg::t_in_beat   key_beat = '0;
    logic                 flag_valid;
    logic                 flag_stall = 1'b0;
    kbsf_pkg::t_out_beat  flag_beat;

    kbsf_pkg::t_in_beat   pending_keys[$];
    kbsf_pkg::t_out_beat  expected_flags[$];

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    logic        rx_hold = 1'b0;
    int          keys_queued = 0;
    int          beats_checked = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    // Model of the keyboard status: pending extended prefix and both flag bytes
    logic        ext_pending = 1'b0;
    logic [7:0]  kb_shift = '0;
    logic [7:0]  kb_press = '0;

    keyboard_shift_flag_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (key_valid),
        .o_in_stall  (key_stall),
        .i_in_beat   (key_beat),
        .o_out_valid (flag_valid),
        .i_out_stall (flag_stall),
        .o_out_beat  (flag_beat)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Flag model: applies one scan byte to the status bytes and returns
    // the beat the block should produce for it.
    // ------------------------------------------------------------------
    function automatic kbsf_pkg::t_out_beat decode_key(input kbsf_pkg::t_in_beat beat);
        kbsf_pkg::t_out_beat res;
        logic [6:0] code;
        logic       brk;
        logic       ext;
        logic       modifier;
        logic       pause;
        int         flag_bit;
        int         press_bit;
        res       = '0;
        code      = beat.scan_code[6:0];
        brk       = beat.scan_code[kbsf_pkg::BREAK_BIT];
        modifier  = 1'b1;
        pause     = 1'b0;
        flag_bit  = -1;
        press_bit = -1;

        // The prefix byte itself counts as extended (it decodes as a break of 0x60)
        if (beat.scan_code == kbsf_pkg::SC_PREFIX)
            ext_pending = 1'b1;
        ext = ext_pending;

        case (code)
            kbsf_pkg::SC_RSHIFT: flag_bit = kbsf_pkg::FB_RSHIFT;
            kbsf_pkg::SC_LSHIFT: flag_bit = kbsf_pkg::FB_LSHIFT;
            kbsf_pkg::SC_CTRL: begin
                // right ctrl (extended) has no press bit
                flag_bit = kbsf_pkg::FB_CTRL;
                if (!ext)
                    press_bit = kbsf_pkg::PB_LCTRL;
            end
            kbsf_pkg::SC_SYSRQ: ;
            kbsf_pkg::SC_ALT: begin
                flag_bit = kbsf_pkg::FB_ALT;
                if (!ext)
                    press_bit = kbsf_pkg::PB_LALT;
            end
            kbsf_pkg::SC_SCROLL: begin
                // press bits of the lock keys sit at the same positions as their flags
                flag_bit = kbsf_pkg::FB_SCROLL;
                if (!ext)
                    press_bit = kbsf_pkg::FB_SCROLL;
            end
            kbsf_pkg::SC_NUMPAUSE: begin
                // extended 0x45 is num lock; plain make is pause, plain break does nothing
                if (ext) begin
                    flag_bit  = kbsf_pkg::FB_NUM;
                    press_bit = kbsf_pkg::FB_NUM;
                end else begin
                    pause = !brk;
                end
            end
            kbsf_pkg::SC_CAPS: begin
                flag_bit  = kbsf_pkg::FB_CAPS;
                press_bit = kbsf_pkg::FB_CAPS;
            end
            kbsf_pkg::SC_INSERT: begin
                flag_bit  = kbsf_pkg::FB_INSERT;
                press_bit = kbsf_pkg::FB_INSERT;
                modifier  = 1'b0;
            end
            default: modifier = 1'b0;
        endcase

        if (!brk) begin
            if (press_bit >= 0)
                kb_press[press_bit] = 1'b1;
            if (flag_bit >= 0) begin
                if (kbsf_pkg::HELD_MASK[flag_bit])
                    kb_shift[flag_bit] = 1'b1;
                else
                    kb_shift[flag_bit] = ~kb_shift[flag_bit];
            end
        end else begin
            // break: held bits drop, lock bits keep their toggled state
            if (press_bit >= 0)
                kb_press[press_bit] = 1'b0;
            if (flag_bit >= 0 && kbsf_pkg::HELD_MASK[flag_bit])
                kb_shift[flag_bit] = 1'b0;
        end

        if (beat.scan_code != kbsf_pkg::SC_PREFIX)
            ext_pending = 1'b0;

        // Makes give a character or a translation request, bare modifiers give nothing
        if (!brk && !(modifier && beat.ascii_code == 8'h00)) begin
            res.scan_out = beat.scan_code;
            if (beat.ascii_code != 8'h00) begin
                res.char_valid = 1'b1;
                res.char_out   = kb_shift[kbsf_pkg::FB_ALT] ? 8'h00 : beat.ascii_code;
            end else begin
                res.needs_translation = 1'b1;
            end
        end
        res.shift_flags = kb_shift;
        res.press_flags = kb_press;
        res.pause_event = pause;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        $display("ERROR beat %0d %s: got %02h, want %02h", beats_checked, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_flags(input kbsf_pkg::t_out_beat got);
        kbsf_pkg::t_out_beat want;
        if (expected_flags.size() == 0) begin
            report_mismatch("beat with nothing outstanding", got.scan_out, 8'h00);
            return;
        end
        want = expected_flags.pop_front();
        compare_field("char_valid", 8'(got.char_valid), 8'(want.char_valid));
        compare_field("char_out", got.char_out, want.char_out);
        compare_field("scan_out", got.scan_out, want.scan_out);
        compare_field("needs_translation", 8'(got.needs_translation),
                      8'(want.needs_translation));
        compare_field("shift_flags", got.shift_flags, want.shift_flags);
        compare_field("press_flags", got.press_flags, want.press_flags);
        compare_field("pause_event", 8'(got.pause_event), 8'(want.pause_event));
        beats_checked++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the next pending key beat; the payload only moves
    // once the current beat has gone in. The model runs at acceptance so
    // it sees beats in the order the block does.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_valid <= 1'b0;
        end else begin
            if (key_valid && !key_stall)
                expected_flags.push_back(decode_key(key_beat));
            if (!key_valid || !key_stall) begin
                if (pending_keys.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    key_valid <= 1'b1;
                    key_beat  <= pending_keys.pop_front();
                end else begin
                    key_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes a flag beat whenever one is offered and not stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flag_stall <= 1'b0;
        end else begin
            if (flag_valid && !flag_stall)
                check_flags(flag_beat);
            flag_stall <= rx_hold || ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_key(input logic [7:0] scan, input logic [7:0] ascii);
        kbsf_pkg::t_in_beat beat;
        beat.scan_code  = scan;
        beat.ascii_code = ascii;
        pending_keys.push_back(beat);
        keys_queued++;
    endtask

    // A make or break, with the extended prefix in front when asked
    task automatic send_key(input logic [6:0] code, input logic brk, input logic ext,
                            input logic [7:0] ascii);
        if (ext)
            push_key(kbsf_pkg::SC_PREFIX,
                     ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h00);
        push_key({brk, code}, ascii);
    endtask

    function automatic logic [6:0] special_code();
        case ($urandom_range(8))
            0: return kbsf_pkg::SC_RSHIFT;
            1: return kbsf_pkg::SC_LSHIFT;
            2: return kbsf_pkg::SC_CTRL;
            3: return kbsf_pkg::SC_SYSRQ;
            4: return kbsf_pkg::SC_ALT;
            5: return kbsf_pkg::SC_SCROLL;
            6: return kbsf_pkg::SC_NUMPAUSE;
            7: return kbsf_pkg::SC_CAPS;
            default: return kbsf_pkg::SC_INSERT;
        endcase
    endfunction

    function automatic logic [7:0] random_ascii();
        if ($urandom_range(99) < 40)
            return 8'h00;
        return 8'($urandom_range(255, 1));
    endfunction

    // Mostly well-formed typing: chords (modifier held over a few keys) and
    // taps, with some raw noise bytes mixed in.
    task automatic queue_typing(input int count);
        int         target;
        int         kind;
        int         n;
        logic [6:0] held;
        logic [6:0] code;
        logic       ext;
        logic [7:0] ascii;
        target = keys_queued + count;
        while (keys_queued < target) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                push_key(8'($urandom_range(255)), 8'($urandom_range(255)));
            end else if (kind < 55) begin
                held  = special_code();
                ext   = ($urandom_range(2) == 0);
                ascii = ($urandom_range(4) == 0) ? random_ascii() : 8'h00;
                send_key(held, 1'b0, ext, ascii);
                n = $urandom_range(4, 1);
                repeat (n) begin
                    code = 7'($urandom_range(127));
                    send_key(code, 1'b0, $urandom_range(5) == 0, random_ascii());
                    if ($urandom_range(1))
                        send_key(code, 1'b1, 1'b0, 8'h00);
                end
                send_key(held, 1'b1, ext, ($urandom_range(5) == 0) ? random_ascii() : 8'h00);
            end else begin
                code = $urandom_range(1) ? special_code() : 7'($urandom_range(127));
                ext  = ($urandom_range(3) == 0);
                send_key(code, 1'b0, ext, random_ascii());
                if ($urandom_range(9) < 7)
                    send_key(code, 1'b1, ext, ($urandom_range(7) == 0) ? random_ascii() : 8'h00);
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // Sender waits until every outstanding beat has come back
    task automatic drain();
        while (pending_keys.size() != 0 || key_valid || expected_flags.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, modifier with a character, extended
        // ctrl/alt/scroll, pause versus num lock, sysrq, caps, insert.
        set_idling(0, 0);
        push_key(8'h00, 8'h00);
        push_key(8'hFF, 8'hFF);
        send_key(kbsf_pkg::SC_RSHIFT, 1'b0, 1'b0, 8'h2B);
        push_key(8'h1E, 8'h61);
        send_key(kbsf_pkg::SC_RSHIFT, 1'b1, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_CTRL, 1'b0, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_CTRL, 1'b1, 1'b1, 8'h00);   // right ctrl break leaves left press bit
        send_key(kbsf_pkg::SC_CTRL, 1'b1, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_ALT, 1'b0, 1'b0, 8'h00);
        push_key(8'h1E, 8'h61);                           // character blanked with alt down
        send_key(kbsf_pkg::SC_ALT, 1'b0, 1'b1, 8'h00);
        send_key(kbsf_pkg::SC_ALT, 1'b1, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_SCROLL, 1'b0, 1'b1, 8'h00);
        send_key(kbsf_pkg::SC_SCROLL, 1'b0, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_SCROLL, 1'b1, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_NUMPAUSE, 1'b0, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_NUMPAUSE, 1'b1, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_NUMPAUSE, 1'b0, 1'b1, 8'h00);
        send_key(kbsf_pkg::SC_SYSRQ, 1'b0, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_CAPS, 1'b0, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_INSERT, 1'b0, 1'b0, 8'h00);
        send_key(kbsf_pkg::SC_INSERT, 1'b1, 1'b0, 8'h30);
        drain();

        // Back to back, with one long hold-off to fill the block
        set_idling(0, 0);
        queue_typing(360);
        fork
            hold_receiver(120);
        join_none
        drain();

        set_idling(55, 0);
        queue_typing(360);
        drain();

        set_idling(0, 55);
        queue_typing(360);
        fork
            hold_receiver(80);
        join_none
        drain();

        set_idling(15, 15);
        queue_typing(360);
        drain();

        // Let any stray beat surface before the verdict
        repeat (10) @(negedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> keyboard_shift_flag_tracker.f
design/kbsf_pkg.sv
design/kbsf_decode.sv
design/keyboard_shift_flag_tracker.sv
design/kbsf_checker.sv
verif/keyboard_shift_flag_tracker_tb.sv
